FILE: sv/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared constants, register indexes, unit select codes and the
// controller/datapath interface structs for the separation force block.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF = 8;

  localparam int ACC_W     = 48;   // accumulator width
  localparam int OUT_W     = 25;   // force component width
  localparam int OUT_TDW   = ((3 * OUT_W + 7) / 8) * 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W     = 16;
  localparam int QR_W      = 24;
  localparam int MF_W      = 16;
  localparam int R_W       = RAD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_AGENT_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_RANGE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_RADIUS = 2'd3;

  localparam logic [RAD_W-1:0] AGENT_RADIUS_RST     = 16'd100;
  localparam logic [QR_W-1:0]  QUERY_RANGE_RST      = 24'd1200;
  localparam logic [MF_W-1:0]  MAX_FORCE_RST        = 16'd2500;
  localparam logic [RAD_W-1:0] NEIGHBOUR_RADIUS_RST = 16'd1000;

  // multiplier operand selects
  localparam logic [1:0] MS_COMP = 2'd0;  // neighbour numerator
  localparam logic [1:0] MS_FSQ  = 2'd1;  // square of a sum
  localparam logic [1:0] MS_FC   = 2'd2;  // sum times cap

  localparam logic DV_COMP = 1'b0;
  localparam logic DV_FIN  = 1'b1;

  localparam logic SQ_D2 = 1'b0;
  localparam logic SQ_L  = 1'b1;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_PASS  = 2'd1;
  localparam logic [1:0] RES_CLAMP = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       mag_en;
    logic       d2_acc;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       div_start;
    logic       div_sel;
    logic       sqrt_start;
    logic       sqrt_sel;
    logic       root_ld;
    logic       sum_upd;
    logic       l_acc;
    logic       res_ld;
    logic [1:0] res_mode;
    logic       emit;
    logic [1:0] comp;
  } ssf_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic enabled;
    logic d2_zero;
    logic out_rng;
    logic mode_a;
    logic clamp;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
  } ssf_stat_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: sv/ssf_div.sv
// ----------------------------------------------------------------------------
// ssf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssf_div #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign trial   = {rem_r, q_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: sv/ssf_sqrt.sv
// ----------------------------------------------------------------------------
// ssf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ssf_sqrt #(
  parameter int RAD_W = 96
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   rad,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int HW    = RAD_W / 2;
  localparam int CNT_W = $clog2(HW + 1);

  logic [RAD_W-1:0] rad_r;
  logic [HW-1:0]    root_r;
  logic [HW+1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [HW+3:0] rem_sh;
  logic [HW+3:0] trial;
  logic [HW+3:0] diff;
  logic          ge;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (HW+4)'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(HW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      root_r <= {root_r[HW-2:0], ge};
      rem_r  <= ge ? diff[HW+1:0] : rem_sh[HW+1:0];
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: sv/ssf_dp.sv
// ----------------------------------------------------------------------------
// ssf_dp
// Datapath: config registers, item registers, shift-add multiplier,
// divider and square-root units, accumulators and the output register.
// ----------------------------------------------------------------------------
module ssf_dp #(
  parameter int POS_WIDTH = ssf_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS = ssf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ssf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [6*POS_WIDTH-1:0]         in_pos,
  input  logic                           in_is_self,
  input  logic                           in_last,
  input  ssf_pkg::ssf_cmd_t              cmd,
  output ssf_pkg::ssf_stat_t             st,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ssf_pkg::OUT_W-1:0]      force_x,
  output logic [ssf_pkg::OUT_W-1:0]      force_y,
  output logic [ssf_pkg::OUT_W-1:0]      force_z
);

  localparam int PW   = POS_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int ACCW = ssf_pkg::ACC_W;
  localparam int OW   = ssf_pkg::OUT_W;
  localparam int MAGW = PW + 1;
  localparam int D2W  = 2 * MAGW + 2;
  localparam int CW   = ssf_pkg::MF_W + F;
  localparam int RW   = ssf_pkg::R_W;
  localparam int RCW  = RW + CW;
  localparam int LW   = 2 * ACCW;
  localparam int MAW  = ssf_pkg::imax(RCW, ssf_pkg::imax(ACCW, CW));
  localparam int MBW  = ssf_pkg::imax(MAGW, ssf_pkg::imax(ACCW, CW));
  localparam int PRW  = MAW + MBW;
  localparam int NUMW = ssf_pkg::imax(RCW + MAGW,
                                      ssf_pkg::imax(CW + MAGW + F, ACCW + CW));
  localparam int SQW  = ssf_pkg::imax(D2W + 2 * F, LW);
  localparam int RTW  = SQW / 2;
  localparam int DENW = ssf_pkg::imax(D2W, RTW);
  localparam int CMPW = ssf_pkg::imax(D2W, 2 * ssf_pkg::QR_W);
  localparam int MCW  = $clog2(MBW + 1);

  // configuration
  logic [ssf_pkg::RAD_W-1:0] ar_r;
  logic [ssf_pkg::QR_W-1:0]  qr_r;
  logic [ssf_pkg::MF_W-1:0]  mf_r;
  logic [ssf_pkg::RAD_W-1:0] nr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ar_r <= ssf_pkg::AGENT_RADIUS_RST;
      qr_r <= ssf_pkg::QUERY_RANGE_RST;
      mf_r <= ssf_pkg::MAX_FORCE_RST;
      nr_r <= ssf_pkg::NEIGHBOUR_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssf_pkg::REG_AGENT_RADIUS:     ar_r <= cfg_wdata[ssf_pkg::RAD_W-1:0];
        ssf_pkg::REG_QUERY_RANGE:      qr_r <= cfg_wdata[ssf_pkg::QR_W-1:0];
        ssf_pkg::REG_MAX_FORCE:        mf_r <= cfg_wdata[ssf_pkg::MF_W-1:0];
        ssf_pkg::REG_NEIGHBOUR_RADIUS: nr_r <= cfg_wdata[ssf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic          enabled;
  logic [CW-1:0] c_w;
  logic [RW-1:0] r_w;

  assign enabled = (ar_r != '0) && (qr_r != '0) && (mf_r != '0);
  assign c_w     = {mf_r, {F{1'b0}}};
  assign r_w     = {1'b0, ar_r} + {1'b0, nr_r};

  // item registers
  logic signed [MAGW-1:0] d_r [3];
  logic [MAGW-1:0]        a_r [3];
  logic                   is_self_r;
  logic                   last_r;
  logic [2*ssf_pkg::QR_W-1:0] qr2_r;
  logic [2*RW-1:0]        rr_r;
  logic [2*CW-1:0]        c2_r;
  logic [RCW-1:0]         rc_r;
  logic [D2W-1:0]         dist2_r;
  logic [LW-1:0]          l_r;
  logic [RTW-1:0]         root_r;
  logic [ACCW-1:0]        sum_r [3];
  logic [OW-1:0]          res_r [3];
  logic [PRW-1:0]         prod_r;

  logic [MAGW-1:0]   a_sel;
  logic [2*MAGW-1:0] sq_w;
  logic [ACCW-1:0]   sum_sel;
  logic [ACCW-1:0]   smag_sel;

  assign a_sel    = a_r[cmd.comp];
  assign sq_w     = a_sel * a_sel;
  assign sum_sel  = sum_r[cmd.comp];
  assign smag_sel = sum_sel[ACCW-1] ? (ACCW'(0) - sum_sel) : sum_sel;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k] <= $signed({in_pos[k*PW + PW - 1], in_pos[k*PW +: PW]})
                - $signed({in_pos[(k+3)*PW + PW - 1], in_pos[(k+3)*PW +: PW]});
      end
      is_self_r <= in_is_self;
      last_r    <= in_last;
      qr2_r     <= (2*ssf_pkg::QR_W)'(qr_r) * (2*ssf_pkg::QR_W)'(qr_r);
      rr_r      <= (2*RW)'(r_w) * (2*RW)'(r_w);
      c2_r      <= (2*CW)'(c_w) * (2*CW)'(c_w);
      rc_r      <= RCW'(r_w) * RCW'(c_w);
      dist2_r   <= '0;
      l_r       <= '0;
    end else begin
      if (cmd.mag_en) begin
        for (int k = 0; k < 3; k++) begin
          a_r[k] <= d_r[k][MAGW-1] ? (MAGW'(0) - MAGW'(d_r[k])) : MAGW'(d_r[k]);
        end
      end
      if (cmd.d2_acc) dist2_r <= dist2_r + D2W'(sq_w);
      if (cmd.l_acc)  l_r     <= l_r + prod_r[LW-1:0];
    end
  end

  // shift-add multiplier, MSB of the second operand first
  logic [MAW-1:0] mul_a_r;
  logic [MBW-1:0] mul_b_r;
  logic [MCW-1:0] mcnt_r;
  logic           mul_busy_r;
  logic           mul_done_r;
  logic [MAW-1:0] ma_in;
  logic [MBW-1:0] mb_in;
  logic           mode_a;

  assign mode_a = dist2_r > D2W'(rr_r);

  always_comb begin
    case (cmd.mul_sel)
      ssf_pkg::MS_COMP: begin
        ma_in = mode_a ? MAW'(rc_r) : MAW'(c_w);
        mb_in = MBW'(a_sel);
      end
      ssf_pkg::MS_FSQ: begin
        ma_in = MAW'(smag_sel);
        mb_in = MBW'(smag_sel);
      end
      ssf_pkg::MS_FC: begin
        ma_in = MAW'(smag_sel);
        mb_in = MBW'(c_w);
      end
      default: begin
        ma_in = '0;
        mb_in = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mcnt_r     <= '0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mcnt_r     <= MCW'(MBW);
      end else if (mul_busy_r) begin
        mcnt_r <= mcnt_r - MCW'(1);
        if (mcnt_r == MCW'(1)) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_a_r <= ma_in;
      mul_b_r <= mb_in;
      prod_r  <= '0;
    end else if (mul_busy_r) begin
      prod_r  <= {prod_r[PRW-2:0], 1'b0}
               + (mul_b_r[MBW-1] ? PRW'(mul_a_r) : PRW'(0));
      mul_b_r <= {mul_b_r[MBW-2:0], 1'b0};
    end
  end

  // divider and square root
  logic [NUMW-1:0] div_num;
  logic [DENW-1:0] div_den;
  logic [NUMW-1:0] quo;
  logic            div_done;
  logic [SQW-1:0]  sq_rad;
  logic [RTW-1:0]  sq_root;
  logic            sqrt_done;

  always_comb begin
    if (cmd.div_sel == ssf_pkg::DV_COMP) begin
      div_num = mode_a ? NUMW'(prod_r) : (NUMW'(prod_r) << F);
      div_den = mode_a ? DENW'(dist2_r) : DENW'(root_r);
    end else begin
      div_num = NUMW'(prod_r);
      div_den = DENW'(root_r);
    end
  end

  assign sq_rad = (cmd.sqrt_sel == ssf_pkg::SQ_D2) ? (SQW'(dist2_r) << (2 * F))
                                                   : SQW'(l_r);

  ssf_div #(.NUM_W(NUMW), .DEN_W(DENW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  ssf_sqrt #(.RAD_W(SQW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sq_rad),
    .done  (sqrt_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.root_ld) root_r <= sq_root;
  end

  // capped quotient
  logic [CW-1:0] v_w;
  logic [OW-1:0] vo_w;

  assign v_w  = (quo > NUMW'(c_w)) ? c_w : quo[CW-1:0];
  assign vo_w = OW'(v_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (cmd.emit) begin
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
    end else if (cmd.sum_upd) begin
      sum_r[cmd.comp] <= d_r[cmd.comp][MAGW-1] ? (sum_sel - ACCW'(v_w))
                                               : (sum_sel + ACCW'(v_w));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      case (cmd.res_mode)
        ssf_pkg::RES_ZERO: begin
          for (int k = 0; k < 3; k++) res_r[k] <= '0;
        end
        ssf_pkg::RES_PASS: begin
          for (int k = 0; k < 3; k++) res_r[k] <= sum_r[k][OW-1:0];
        end
        ssf_pkg::RES_CLAMP: begin
          res_r[cmd.comp] <= sum_sel[ACCW-1] ? (OW'(0) - vo_w) : vo_w;
        end
        default: ;
      endcase
    end
  end

  // output register
  logic          out_valid_r;
  logic [OW-1:0] fx_r, fy_r, fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      fx_r <= res_r[0];
      fy_r <= res_r[1];
      fz_r <= res_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign force_x   = fx_r;
  assign force_y   = fy_r;
  assign force_z   = fz_r;

  assign st.skip      = is_self_r || !enabled;
  assign st.last      = last_r;
  assign st.enabled   = enabled;
  assign st.d2_zero   = (dist2_r == '0);
  assign st.out_rng   = CMPW'(dist2_r) >= CMPW'(qr2_r);
  assign st.mode_a    = mode_a;
  assign st.clamp     = l_r > LW'(c2_r);
  assign st.mul_done  = mul_done_r;
  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;
  assign st.out_busy  = out_valid_r && !out_ready;

endmodule

FILE: sv/ssf_ctrl.sv
// ----------------------------------------------------------------------------
// ssf_ctrl
// Sequencer: walks one item through distance, per-component force and,
// on the last item, the length clamp; issues unit starts to the datapath.
// ----------------------------------------------------------------------------
module ssf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssf_pkg::ssf_stat_t st,
  output ssf_pkg::ssf_cmd_t  cmd
);

  logic [4:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  localparam logic [4:0] T_IDLE  = 5'd0;
  localparam logic [4:0] T_MAG   = 5'd1;
  localparam logic [4:0] T_D2    = 5'd2;
  localparam logic [4:0] T_RNG   = 5'd3;
  localparam logic [4:0] T_SQ_W  = 5'd4;
  localparam logic [4:0] T_CMS   = 5'd5;
  localparam logic [4:0] T_CM_W  = 5'd6;
  localparam logic [4:0] T_CD_W  = 5'd7;
  localparam logic [4:0] T_LAST  = 5'd8;
  localparam logic [4:0] T_FSQS  = 5'd9;
  localparam logic [4:0] T_FSQ_W = 5'd10;
  localparam logic [4:0] T_FCMP  = 5'd11;
  localparam logic [4:0] T_FRT_W = 5'd12;
  localparam logic [4:0] T_FMS   = 5'd13;
  localparam logic [4:0] T_FM_W  = 5'd14;
  localparam logic [4:0] T_FD_W  = 5'd15;
  localparam logic [4:0] T_EMIT  = 5'd16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  assign in_ready = (state_r == T_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.comp  = k_r;
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = T_MAG;
        end
      end
      T_MAG: begin
        cmd.mag_en = 1'b1;
        k_nxt      = 2'd0;
        state_nxt  = st.skip ? T_LAST : T_D2;
      end
      T_D2: begin
        cmd.d2_acc = 1'b1;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = T_RNG;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      T_RNG: begin
        if (st.d2_zero || st.out_rng) begin
          state_nxt = T_LAST;
        end else if (st.mode_a) begin
          state_nxt = T_CMS;
        end else begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel   = ssf_pkg::SQ_D2;
          state_nxt      = T_SQ_W;
        end
      end
      T_SQ_W: begin
        if (st.sqrt_done) begin
          cmd.root_ld = 1'b1;
          state_nxt   = T_CMS;
        end
      end
      T_CMS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = ssf_pkg::MS_COMP;
        state_nxt     = T_CM_W;
      end
      T_CM_W: begin
        if (st.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ssf_pkg::DV_COMP;
          state_nxt     = T_CD_W;
        end
      end
      T_CD_W: begin
        if (st.div_done) begin
          cmd.sum_upd = 1'b1;
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = T_LAST;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = T_CMS;
          end
        end
      end
      T_LAST: begin
        k_nxt = 2'd0;
        if (!st.last) begin
          state_nxt = T_IDLE;
        end else if (!st.enabled) begin
          cmd.res_ld   = 1'b1;
          cmd.res_mode = ssf_pkg::RES_ZERO;
          state_nxt    = T_EMIT;
        end else begin
          state_nxt = T_FSQS;
        end
      end
      T_FSQS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = ssf_pkg::MS_FSQ;
        state_nxt     = T_FSQ_W;
      end
      T_FSQ_W: begin
        if (st.mul_done) begin
          cmd.l_acc = 1'b1;
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = T_FCMP;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = T_FSQS;
          end
        end
      end
      T_FCMP: begin
        if (st.clamp) begin
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel   = ssf_pkg::SQ_L;
          state_nxt      = T_FRT_W;
        end else begin
          cmd.res_ld   = 1'b1;
          cmd.res_mode = ssf_pkg::RES_PASS;
          state_nxt    = T_EMIT;
        end
      end
      T_FRT_W: begin
        if (st.sqrt_done) begin
          cmd.root_ld = 1'b1;
          state_nxt   = T_FMS;
        end
      end
      T_FMS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = ssf_pkg::MS_FC;
        state_nxt     = T_FM_W;
      end
      T_FM_W: begin
        if (st.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ssf_pkg::DV_FIN;
          state_nxt     = T_FD_W;
        end
      end
      T_FD_W: begin
        if (st.div_done) begin
          cmd.res_ld   = 1'b1;
          cmd.res_mode = ssf_pkg::RES_CLAMP;
          if (k_r == 2'd2) begin
            k_nxt     = 2'd0;
            state_nxt = T_EMIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = T_FMS;
          end
        end
      end
      T_EMIT: begin
        // wait for the output register to free up
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

endmodule

FILE: sv/separation_steering_force.sv
// ----------------------------------------------------------------------------
// separation_steering_force
// Boids separation: sums capped repulsion from a run of neighbors and emits
// the length-limited vector on the last item.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_tvalid/in_tready  in_tdata positions, in_tuser, in_tlast
//  out      out  out_tvalid/out_tready out_tdata force x, y, z (Q.FRAC_BITS)
//  cfg      in   cfg_we               cfg_addr, cfg_wdata
//
//  One item at a time. The shift-add multiplier, divider and square root are
//  iterative. A skipped item does no force work; an in-range neighbor takes a
//  multiply and a divide per component, after a square root of the distance
//  when that root is needed; a last item adds a square-and-sum per component
//  and, when clamped, a square root and a multiply and divide per component.
//  rst_n is synchronous; sums clear to zero. in_tready drops while an
//  item is in work; a finished result waits in the output register under stall.
// ----------------------------------------------------------------------------
module separation_steering_force #(
  parameter int POS_WIDTH = ssf_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS = ssf_pkg::FRAC_BITS_DEF,
  localparam int IN_TDW   = ((6 * POS_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ssf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // self_x, self_y, self_z, other_x, other_y, other_z
  input  logic [IN_TDW-1:0]             in_tdata,
  // is_self
  input  logic [0:0]                    in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // force_x, force_y, force_z
  output logic [ssf_pkg::OUT_TDW-1:0]   out_tdata
);

  ssf_pkg::ssf_cmd_t  cmd;
  ssf_pkg::ssf_stat_t st;
  logic [ssf_pkg::OUT_W-1:0] fx, fy, fz;

  ssf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ssf_dp #(.POS_WIDTH(POS_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_pos     (in_tdata[6*POS_WIDTH-1:0]),
    .in_is_self (in_tuser[0]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .force_x    (fx),
    .force_y    (fy),
    .force_z    (fz)
  );

  assign out_tdata = ssf_pkg::OUT_TDW'({fz, fy, fx});

endmodule
